FILE: design/vps_pkg.sv
package vps_pkg;

  localparam int PromptW = 16;
  localparam int EventW = 4;
  localparam int TimeW = 32;
  localparam int EntryW = PromptW + EventW + TimeW;

  localparam logic [2:0] OP_POST = 3'd0;
  localparam logic [2:0] OP_TICK = 3'd1;
  localparam logic [2:0] OP_TEST = 3'd2;
  localparam logic [2:0] OP_RESET = 3'd3;
  localparam logic [2:0] OP_LOAD = 3'd4;

  localparam logic [3:0] EV_STOPPED = 4'd0;
  localparam logic [3:0] EV_SEARCH = 4'd1;
  localparam logic [3:0] EV_FOUND = 4'd2;
  localparam logic [3:0] EV_NAME = 4'd3;
  localparam logic [3:0] EV_LOST = 4'd4;
  localparam logic [3:0] EV_GUIDE_FIRST = 4'd5;
  localparam logic [3:0] EV_GUIDE_LAST = 4'd13;

  localparam logic [1:0] ACT_PLAY = 2'd0;
  localparam logic [1:0] ACT_PAUSE = 2'd1;
  localparam logic [1:0] ACT_RESUME = 2'd2;

  localparam logic [2:0] REG_STOP = 3'd0;
  localparam logic [2:0] REG_LOST = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_DELAY = 3'd3;
  localparam logic [2:0] REG_TEST = 3'd4;

  localparam logic [TimeW-1:0] GUIDE_GUARD_MS = 32'd700;

  typedef struct packed {
    logic [PromptW-1:0] prompt;
    logic [EventW-1:0] ev;
    logic [TimeW-1:0] due;
  } entry_t;

  function automatic logic is_guide(logic [EventW-1:0] ev);
    return (ev >= EV_GUIDE_FIRST) && (ev <= EV_GUIDE_LAST);
  endfunction

endpackage

FILE: design/vps_ram.sv
module vps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/voice_prompt_scheduler.sv
// channel | dir | tdata (low bit up)                                   | tuser
// s_axis  | in  | op[2:0] event_req[6:3] target_mode[10:7]             | -
//         |     | now_ms[42:11] table_address[47:43] table_value[63:48] |
// m_axis  | out | action[1:0] prompt[17:2] guard_end[49:18], 56 bits   | -
// Post scans the queue RAM in its drop, coalesce and name steps, each entry
// read through a wait state (S_DROPW, S_ENQW); tick scans it to shift out the head.
// Reset and table load complete in the accepting cycle; test key registers its result.
// After rst all 32 prompt table entries are cleared before s_axis_tready rises.
// Busy until the operation ends and any result is taken on m_axis; one item at a time.
module voice_prompt_scheduler
  import vps_pkg::*;
#(
  parameter int QUEUE_DEPTH = 8,
  parameter int TARGET_MODES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // op, event_req, target_mode, now_ms, table_address, table_value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // action, prompt, guard_end
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 2);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_LOOK = 4'd2;
  localparam logic [3:0] S_DEC = 4'd3;
  localparam logic [3:0] S_DROP = 4'd4;
  localparam logic [3:0] S_ENQ = 4'd5;
  localparam logic [3:0] S_NLOOK = 4'd6;
  localparam logic [3:0] S_NWAIT = 4'd7;
  localparam logic [3:0] S_SHIFT = 4'd8;
  localparam logic [3:0] S_OUT = 4'd9;
  localparam logic [3:0] S_TICK = 4'd10;
  localparam logic [3:0] S_DROPW = 4'd11;
  localparam logic [3:0] S_ENQW = 4'd12;

  logic [3:0] state;
  logic [15:0] stop_guard, lost_guard, status_guard, name_delay, test_prompt;
  logic [2:0] op;
  logic [3:0] ev, mode;
  logic [31:0] now, due;
  logic [15:0] prompt;
  logic [15:0] name_prompt;
  logic name_pending;
  logic [CW-1:0] count, idx, dst;
  logic [31:0] guard_until;
  logic test_playing, test_held;
  logic [5:0] clr;
  logic drop_guide;

  logic tbl_we;
  logic [4:0] tbl_waddr, tbl_raddr;
  logic [15:0] tbl_wdata, tbl_rdata;

  logic q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  entry_t q_wdata, q_rdata;
  logic [CW-1:0] q_rd_idx;

  logic [1:0] out_action;
  logic [15:0] out_prompt;
  logic [31:0] out_guard;

  logic [31:0] diff, add_b;

  vps_ram #(.WIDTH(16), .DEPTH(32)) u_table (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  vps_ram #(.WIDTH(EntryW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata = {6'd0, out_guard, out_prompt, out_action};
  assign q_raddr = q_rd_idx[QW-1:0];
  assign diff = guard_until - now;

  always_comb begin
    unique case (ev)
      EV_STOPPED: add_b = {16'd0, stop_guard};
      EV_LOST: add_b = {16'd0, lost_guard};
      default: add_b = is_guide(ev) ? GUIDE_GUARD_MS : {16'd0, status_guard};
    endcase
  end

  always_comb begin
    tbl_raddr = {1'b0, ev};
    if (state == S_NLOOK || (state == S_LOOK && ev == EV_NAME)) begin
      tbl_raddr = {1'b1, mode};
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      unique case (cfg_index)
        REG_STOP: stop_guard <= cfg_data;
        REG_LOST: lost_guard <= cfg_data;
        REG_STATUS: status_guard <= cfg_data;
        REG_DELAY: name_delay <= cfg_data;
        REG_TEST: test_prompt <= cfg_data;
        default: ;
      endcase
    end
    if (rst) begin
      stop_guard <= '0;
      lost_guard <= '0;
      status_guard <= '0;
      name_delay <= '0;
      test_prompt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    tbl_we <= 1'b0;
    q_we <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      count <= '0;
      guard_until <= '0;
      test_playing <= 1'b0;
      test_held <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          tbl_we <= 1'b1;
          tbl_waddr <= clr[4:0];
          tbl_wdata <= '0;
          clr <= clr + 6'd1;
          if (clr == 6'd31) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op <= s_axis_tdata[2:0];
            ev <= s_axis_tdata[6:3];
            mode <= s_axis_tdata[10:7];
            now <= s_axis_tdata[42:11];
            state <= S_LOOK;
            unique case (s_axis_tdata[2:0])
              OP_POST: state <= S_LOOK;
              OP_TICK: begin
                q_rd_idx <= '0;
                state <= S_TICK;
              end
              OP_TEST: begin
                out_guard <= guard_until;
                state <= S_IDLE;
                if (test_prompt != 16'd0) begin
                  state <= S_OUT;
                  if (!test_playing) begin
                    test_playing <= 1'b1;
                    test_held <= 1'b0;
                    out_action <= ACT_PLAY;
                    out_prompt <= test_prompt;
                  end else begin
                    out_prompt <= '0;
                    test_held <= !test_held;
                    out_action <= test_held ? ACT_RESUME : ACT_PAUSE;
                  end
                end
              end
              OP_RESET: begin
                count <= '0;
                guard_until <= '0;
                test_playing <= 1'b0;
                test_held <= 1'b0;
                state <= S_IDLE;
              end
              OP_LOAD: begin
                tbl_we <= 1'b1;
                tbl_waddr <= s_axis_tdata[47:43];
                tbl_wdata <= s_axis_tdata[63:48];
                state <= S_IDLE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_LOOK: state <= S_DEC;
        S_DEC: begin
          prompt <= tbl_rdata;
          due <= (diff != 0 && !diff[31]) ? guard_until : now;
          name_pending <= 1'b0;
          if (ev > EV_GUIDE_LAST || tbl_rdata == 16'd0 ||
              (ev == EV_NAME && {28'd0, mode} >= TARGET_MODES)) begin
            state <= S_IDLE;
          end else if (ev == EV_STOPPED || ev == EV_LOST) begin
            count <= '0;
            guard_until <= now + add_b;
            out_guard <= now + add_b;
            out_action <= ACT_PLAY;
            out_prompt <= tbl_rdata;
            test_playing <= 1'b0;
            test_held <= 1'b0;
            state <= S_OUT;
          end else begin
            name_pending <= (ev == EV_FOUND);
            drop_guide <= is_guide(ev);
            idx <= '0;
            dst <= '0;
            q_rd_idx <= '0;
            state <= (ev == EV_SEARCH) ? S_ENQW : S_DROPW;
          end
        end
        S_DROPW: state <= S_DROP;
        S_DROP: begin
          if (idx >= count) begin
            count <= dst;
            idx <= '0;
            q_rd_idx <= '0;
            state <= S_ENQW;
          end else begin
            if (drop_guide ? !is_guide(q_rdata.ev) : (q_rdata.ev != EV_SEARCH)) begin
              q_we <= 1'b1;
              q_waddr <= dst[QW-1:0];
              q_wdata <= q_rdata;
              dst <= dst + CW'(1);
            end
            idx <= idx + CW'(1);
            q_rd_idx <= idx + CW'(1);
            state <= S_DROPW;
          end
        end
        S_ENQW: state <= S_ENQ;
        S_ENQ: begin
          if (idx >= count || q_rdata.ev == ev) begin
            if (idx < count || count < CW'(QUEUE_DEPTH)) begin
              q_we <= 1'b1;
              q_waddr <= idx[QW-1:0];
              q_wdata <= '{prompt: prompt, ev: ev, due: due};
              if (idx >= count) count <= count + CW'(1);
            end
            if (name_pending) begin
              name_pending <= 1'b0;
              ev <= EV_NAME;
              due <= due + {16'd0, name_delay};
              state <= S_NLOOK;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            idx <= idx + CW'(1);
            q_rd_idx <= idx + CW'(1);
            state <= S_ENQW;
          end
        end
        S_NLOOK: state <= S_NWAIT;
        S_NWAIT: begin
          prompt <= tbl_rdata;
          idx <= '0;
          q_rd_idx <= '0;
          state <= (tbl_rdata == 16'd0 || {28'd0, mode} >= TARGET_MODES) ? S_IDLE
                                                                     : S_ENQW;
        end
        S_TICK: begin
          state <= S_IDLE;
          if (count != '0 && q_rd_idx == '0) state <= S_SHIFT;
          if (count != '0 && q_rd_idx == '0) q_rd_idx <= '0;
          idx <= CW'(1);
        end
        S_SHIFT: begin
          if (idx == CW'(1) && q_rd_idx == '0) begin
            if ((now - q_rdata.due) >> 31 != 32'd0) begin
              state <= S_IDLE;
            end else begin
              ev <= q_rdata.ev;
              out_prompt <= q_rdata.prompt;
              q_rd_idx <= CW'(1);
              if (count == CW'(1)) begin
                count <= '0;
                state <= S_NLOOK;
              end else begin
                drop_guide <= 1'b0;
                state <= S_SHIFT;
                idx <= CW'(2);
              end
            end
          end else begin
            // read data is the registered RAM output for the previous read index
            if (idx > CW'(2)) begin
              q_we <= 1'b1;
              q_waddr <= QW'(idx - CW'(3));
              q_wdata <= q_rdata;
            end
            if (idx > count) begin
              count <= count - CW'(1);
              state <= S_NLOOK;
            end else begin
              idx <= idx + CW'(1);
              q_rd_idx <= idx;
            end
          end
        end
        S_OUT: begin
          if (m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (op == OP_TICK && (state == S_NLOOK)) begin
        guard_until <= now + add_b;
        out_guard <= now + add_b;
        out_action <= ACT_PLAY;
        test_playing <= 1'b0;
        test_held <= 1'b0;
        state <= S_OUT;
      end
    end
  end

endmodule

FILE: design/vps_checker.sv
module vps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_action: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad action");

  a_silent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[17:2] == 16'd0)
    else $error("pause or resume carries a prompt");

endmodule

bind voice_prompt_scheduler vps_checker u_vps_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
